### rtl/jts_pkg.sv
package jts_pkg;

  localparam int CP_W      = 21;
  localparam int MAX_RES   = 4;
  localparam int RCNT_W    = $clog2(MAX_RES + 1);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW   = $clog2(FIFO_DEPTH + 1);

  // Scan modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_SYM  = 2'd3;

  // String escape states.
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_BSL  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  // Number sub-modes.
  localparam logic [2:0] NM_UNDEC = 3'd0;
  localparam logic [2:0] NM_DEC   = 3'd1;
  localparam logic [2:0] NM_EXP   = 3'd2;
  localparam logic [2:0] NM_EXPD  = 3'd3;
  localparam logic [2:0] NM_HEX   = 3'd4;
  localparam logic [2:0] NM_OCT   = 3'd5;
  localparam logic [2:0] NM_BIN   = 3'd6;

  // Event kinds.
  localparam logic [1:0] EV_BODY = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  // Token types.
  localparam logic [3:0] TT_COMMA  = 4'd0;
  localparam logic [3:0] TT_DOT    = 4'd1;
  localparam logic [3:0] TT_OBJ_O  = 4'd2;
  localparam logic [3:0] TT_OBJ_C  = 4'd3;
  localparam logic [3:0] TT_ARR_O  = 4'd4;
  localparam logic [3:0] TT_ARR_C  = 4'd5;
  localparam logic [3:0] TT_COLON  = 4'd6;
  localparam logic [3:0] TT_STRING = 4'd7;
  localparam logic [3:0] TT_NUMBER = 4'd8;
  localparam logic [3:0] TT_SYMBOL = 4'd9;
  localparam logic [3:0] TT_NULL   = 4'd10;

  // Characters of interest.
  localparam logic [CP_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CP_W-1:0] CH_LF    = 21'h0A;
  localparam logic [CP_W-1:0] CH_CR    = 21'h0D;
  localparam logic [CP_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CP_W-1:0] CH_QUOTE = 21'h22;
  localparam logic [CP_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CP_W-1:0] CH_COMMA = 21'h2C;
  localparam logic [CP_W-1:0] CH_MINUS = 21'h2D;
  localparam logic [CP_W-1:0] CH_DOT   = 21'h2E;
  localparam logic [CP_W-1:0] CH_0     = 21'h30;
  localparam logic [CP_W-1:0] CH_1     = 21'h31;
  localparam logic [CP_W-1:0] CH_7     = 21'h37;
  localparam logic [CP_W-1:0] CH_9     = 21'h39;
  localparam logic [CP_W-1:0] CH_COLON = 21'h3A;
  localparam logic [CP_W-1:0] CH_UA    = 21'h41;
  localparam logic [CP_W-1:0] CH_UB    = 21'h42;
  localparam logic [CP_W-1:0] CH_UE    = 21'h45;
  localparam logic [CP_W-1:0] CH_UF    = 21'h46;
  localparam logic [CP_W-1:0] CH_UO    = 21'h4F;
  localparam logic [CP_W-1:0] CH_UX    = 21'h58;
  localparam logic [CP_W-1:0] CH_LBRK  = 21'h5B;
  localparam logic [CP_W-1:0] CH_BSL   = 21'h5C;
  localparam logic [CP_W-1:0] CH_RBRK  = 21'h5D;
  localparam logic [CP_W-1:0] CH_LA    = 21'h61;
  localparam logic [CP_W-1:0] CH_LB    = 21'h62;
  localparam logic [CP_W-1:0] CH_LE    = 21'h65;
  localparam logic [CP_W-1:0] CH_LF_   = 21'h66;
  localparam logic [CP_W-1:0] CH_LN    = 21'h6E;
  localparam logic [CP_W-1:0] CH_LO    = 21'h6F;
  localparam logic [CP_W-1:0] CH_LR    = 21'h72;
  localparam logic [CP_W-1:0] CH_LT    = 21'h74;
  localparam logic [CP_W-1:0] CH_LU    = 21'h75;
  localparam logic [CP_W-1:0] CH_LX    = 21'h78;
  localparam logic [CP_W-1:0] CH_LBRC  = 21'h7B;
  localparam logic [CP_W-1:0] CH_RBRC  = 21'h7D;

  localparam logic [CP_W-1:0] NULL_TEXT [4] = '{21'h6E, 21'h75, 21'h6C, 21'h6C};

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  esc;
    logic [15:0] hex_accum;
    logic [2:0]  hex_rem;
    logic [2:0]  num_mode;
    logic        dot;
    logic        upper;
    logic [2:0]  null_cnt;
    logic        null_miss;
  } scan_st_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0]      ttype;
    logic [CP_W-1:0] ch;
    logic            last;
  } result_t;

  typedef struct packed {
    logic    vld;
    result_t res;
  } idle_out_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [3:0] ttype,
                                     logic [CP_W-1:0] ch);
    result_t r;
    r.kind  = kind;
    r.ttype = ttype;
    r.ch    = ch;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [CP_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_white(logic [CP_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Valid flag in the top bit, digit value below.
  function automatic logic [4:0] hex_val(logic [CP_W-1:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (is_digit(c)) begin
      v = {1'b1, 4'(c - CH_0)};
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      v = {1'b1, 4'(c - CH_UA + 21'd10)};
    end else if ((c >= CH_LA) && (c <= CH_LF_)) begin
      v = {1'b1, 4'(c - CH_LA + 21'd10)};
    end
    return v;
  endfunction

  // Valid flag in the top bit, token type below.
  function automatic logic [4:0] punct(logic [CP_W-1:0] c);
    logic [4:0] p;
    p = 5'd0;
    if (c == CH_COMMA)      p = {1'b1, TT_COMMA};
    else if (c == CH_DOT)   p = {1'b1, TT_DOT};
    else if (c == CH_LBRC)  p = {1'b1, TT_OBJ_O};
    else if (c == CH_RBRC)  p = {1'b1, TT_OBJ_C};
    else if (c == CH_LBRK)  p = {1'b1, TT_ARR_O};
    else if (c == CH_RBRK)  p = {1'b1, TT_ARR_C};
    else if (c == CH_COLON) p = {1'b1, TT_COLON};
    return p;
  endfunction

  function automatic logic sym_cont(logic [CP_W-1:0] c);
    logic [4:0] p;
    p = punct(c);
    return !is_white(c) && (c != CH_QUOTE) && ((c == CH_DOT) || !p[4]);
  endfunction

  function automatic scan_st_t sym_append(scan_st_t st, logic [CP_W-1:0] c);
    scan_st_t s;
    s = st;
    if (!s.null_miss && (s.null_cnt < 3'd4) && (c == NULL_TEXT[s.null_cnt[1:0]])) begin
      s.null_cnt = s.null_cnt + 3'd1;
    end else begin
      s.null_miss = 1'b1;
    end
    return s;
  endfunction

  // State after scanning a character from idle.
  function automatic scan_st_t idle_state(scan_st_t st, logic [CP_W-1:0] c);
    scan_st_t   s;
    logic [4:0] p;
    s = st;
    p = punct(c);
    if (is_white(c) || p[4]) begin
      s = st;
    end else if (c == CH_QUOTE) begin
      s.mode = MODE_STR;
      s.esc  = ESC_NONE;
    end else if (is_digit(c) || (c == CH_MINUS)) begin
      s.mode     = MODE_NUM;
      s.num_mode = (c == CH_0) ? NM_UNDEC : NM_DEC;
      s.dot      = 1'b0;
      s.upper    = 1'b0;
    end else begin
      s.mode      = MODE_SYM;
      s.null_cnt  = 3'd0;
      s.null_miss = 1'b0;
      s = sym_append(s, c);
    end
    return s;
  endfunction

  // Result, if any, of scanning a character from idle.
  function automatic idle_out_t idle_out(logic [CP_W-1:0] c);
    idle_out_t  o;
    logic [4:0] p;
    p = punct(c);
    o.vld = 1'b0;
    o.res = mk_res(EV_BODY, TT_SYMBOL, c);
    if (is_white(c) || (c == CH_QUOTE)) begin
      o.vld = 1'b0;
    end else if (p[4]) begin
      o.vld = 1'b1;
      o.res = mk_res(EV_DONE, p[3:0], '0);
    end else if (is_digit(c) || (c == CH_MINUS)) begin
      o.vld = 1'b1;
      o.res = mk_res(EV_BODY, TT_NUMBER, c);
    end else begin
      o.vld = 1'b1;
    end
    return o;
  endfunction

endpackage

### rtl/json_token_scanner.sv
// Streaming JSON tokenizer, one Unicode code point per input transaction.
// Input channel: in_valid/in_ready with in_code_point. Result channel:
// out_valid/out_ready with out_event_kind, out_token_type, out_char_value
// and out_last; out_last marks the final result caused by a character.
// A character yields zero to four results; an opening quote, an escape
// prefix, a held exponent letter and whitespace outside a token yield none.
// A character accepted into the input register is scanned into the result
// queue once the queue has room; its results then wait there behind earlier ones.
// Throughput: one character per cycle while each gives at most one result
// and the receiver takes one every cycle; otherwise the result port, which
// drains one result per cycle, sets the pace. A character is scanned only
// when the eight-entry result queue has room for four results, so in_ready
// falls while a character waits in the input register and the queue holds
// more than four.
// When the receiver stalls, results wait in the queue and the input
// register holds the next character until room appears.
// Synchronous reset empties the queue and the input register and returns
// the scanner to idle outside any token.
module json_token_scanner
  import jts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CP_W-1:0] in_code_point,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_event_kind,
  output logic [3:0]      out_token_type,
  output logic [CP_W-1:0] out_char_value,
  output logic            out_last
);

  logic               in_vld_r;
  logic [CP_W-1:0]    in_cp_r;
  scan_st_t           st_r, st_nxt;
  result_t            scan_res [MAX_RES];
  logic [RCNT_W-1:0]  scan_cnt;
  logic [RCNT_W-1:0]  push_cnt;
  logic [FIFO_CW-1:0] fifo_count;
  logic               scan_fire;
  result_t            head;

  localparam logic [FIFO_CW-1:0] ROOM_LIMIT = FIFO_CW'(FIFO_DEPTH - MAX_RES);

  assign scan_fire = in_vld_r && (fifo_count <= ROOM_LIMIT);
  assign in_ready  = !in_vld_r || scan_fire;
  assign push_cnt  = scan_fire ? scan_cnt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cp_r <= in_code_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (scan_fire) begin
      st_r <= st_nxt;
    end
  end

  jts_scan u_scan (
    .c       (in_cp_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (scan_res),
    .res_cnt (scan_cnt)
  );

  jts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (scan_res),
    .pop       (out_valid && out_ready),
    .head      (head),
    .count     (fifo_count)
  );

  assign out_valid      = (fifo_count != '0);
  assign out_event_kind = head.kind;
  assign out_token_type = head.ttype;
  assign out_char_value = head.ch;
  assign out_last       = head.last;

endmodule

### rtl/jts_scan.sv
module jts_scan
  import jts_pkg::*;
(
  input  logic [CP_W-1:0]   c,
  input  scan_st_t          st,
  output scan_st_t          st_nxt,
  output result_t           res [MAX_RES],
  output logic [RCNT_W-1:0] res_cnt
);

  localparam logic [1:0] NE_TAKEN = 2'd0;
  localparam logic [1:0] NE_ENDS  = 2'd1;
  localparam logic [1:0] NE_EXP   = 2'd2;

  scan_st_t          s;
  result_t           ra [MAX_RES];
  logic [RCNT_W-1:0] n;
  logic              sym_now;
  logic [1:0]        nend;
  logic [4:0]        hv;
  logic [15:0]       acc;
  logic [2:0]        rem;
  logic [CP_W-1:0]   rc;
  idle_out_t         io;

  always_comb begin
    s       = st;
    n       = '0;
    sym_now = 1'b0;
    nend    = NE_TAKEN;
    hv      = hex_val(c);
    acc     = {st.hex_accum[11:0], hv[3:0]};
    rem     = st.hex_rem - 3'd1;
    rc      = c;
    io      = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      ra[i] = '0;
    end

    unique case (st.mode)
      MODE_STR: begin
        unique case (st.esc)
          ESC_BSL: begin
            if (c == CH_LU) begin
              s.esc       = ESC_HEX;
              s.hex_accum = '0;
              s.hex_rem   = 3'd4;
            end else begin
              s.esc = ESC_NONE;
              priority if (c == CH_LT) rc = CH_TAB;
              else if (c == CH_LN)     rc = CH_LF;
              else if (c == CH_LR)     rc = CH_CR;
              else                     rc = c;
              ra[n[1:0]] = mk_res(EV_BODY, TT_STRING, rc);
              n = n + 1'b1;
            end
          end
          ESC_HEX: begin
            if (!hv[4]) begin
              ra[n[1:0]] = mk_res(EV_ERR, TT_STRING, '0);
              n = n + 1'b1;
              s.esc       = ESC_NONE;
              s.hex_accum = '0;
              s.hex_rem   = '0;
              s.mode      = MODE_IDLE;
            end else begin
              s.hex_accum = acc;
              s.hex_rem   = rem;
              if (rem == 3'd0) begin
                s.esc = ESC_NONE;
                ra[n[1:0]] = mk_res(EV_BODY, TT_STRING, CP_W'(acc));
                n = n + 1'b1;
                s.hex_accum = '0;
              end
            end
          end
          default: begin
            // The unused escape code behaves as the normal state.
            if (c == CH_QUOTE) begin
              ra[n[1:0]] = mk_res(EV_DONE, TT_STRING, '0);
              n = n + 1'b1;
              s.mode = MODE_IDLE;
            end else if (c == CH_BSL) begin
              s.esc = ESC_BSL;
            end else begin
              ra[n[1:0]] = mk_res(EV_BODY, TT_STRING, c);
              n = n + 1'b1;
            end
          end
        endcase
      end

      MODE_NUM: begin
        unique case (st.num_mode)
          NM_UNDEC: begin
            priority if ((c == CH_LX) || (c == CH_UX)) s.num_mode = NM_HEX;
            else if ((c == CH_LO) || (c == CH_UO))     s.num_mode = NM_OCT;
            else if ((c == CH_LB) || (c == CH_UB))     s.num_mode = NM_BIN;
            else if (c == CH_DOT) begin
              s.dot      = 1'b1;
              s.num_mode = NM_DEC;
            end
            else if (is_digit(c)) s.num_mode = NM_DEC;
            else                  nend = NE_ENDS;
            if (nend == NE_TAKEN) begin
              ra[n[1:0]] = mk_res(EV_BODY, TT_NUMBER, c);
              n = n + 1'b1;
            end
          end
          NM_DEC: begin
            if (is_digit(c) || ((c == CH_DOT) && !st.dot)) begin
              if (c == CH_DOT) s.dot = 1'b1;
              ra[n[1:0]] = mk_res(EV_BODY, TT_NUMBER, c);
              n = n + 1'b1;
            end else if (((c == CH_LE) || (c == CH_UE)) && st.dot) begin
              // The letter is held back until the sign shows it belongs here.
              s.upper    = (c == CH_UE);
              s.num_mode = NM_EXP;
            end else begin
              nend = NE_ENDS;
            end
          end
          NM_EXP: begin
            if ((c == CH_PLUS) || (c == CH_MINUS)) begin
              s.num_mode = NM_EXPD;
              ra[n[1:0]] = mk_res(EV_BODY, TT_NUMBER, CH_LE);
              n = n + 1'b1;
              ra[n[1:0]] = mk_res(EV_BODY, TT_NUMBER, c);
              n = n + 1'b1;
            end else begin
              nend = NE_EXP;
            end
          end
          NM_EXPD, NM_HEX, NM_OCT, NM_BIN: begin
            priority if (st.num_mode == NM_EXPD) nend = is_digit(c) ? NE_TAKEN : NE_ENDS;
            else if (st.num_mode == NM_HEX)      nend = hv[4] ? NE_TAKEN : NE_ENDS;
            else if (st.num_mode == NM_OCT)
              nend = ((c >= CH_0) && (c <= CH_7)) ? NE_TAKEN : NE_ENDS;
            else
              nend = ((c == CH_0) || (c == CH_1)) ? NE_TAKEN : NE_ENDS;
            if (nend == NE_TAKEN) begin
              ra[n[1:0]] = mk_res(EV_BODY, TT_NUMBER, c);
              n = n + 1'b1;
            end
          end
          default: nend = NE_ENDS;
        endcase

        if (nend != NE_TAKEN) begin
          ra[n[1:0]] = mk_res(EV_DONE, TT_NUMBER, '0);
          n = n + 1'b1;
          s.mode = MODE_IDLE;
          // An unsigned exponent re-scans its letter first, then this character.
          if (nend == NE_EXP) rc = st.upper ? CH_UE : CH_LE;
          io = idle_out(rc);
          s  = idle_state(s, rc);
          if (io.vld) begin
            ra[n[1:0]] = io.res;
            n = n + 1'b1;
          end
          sym_now = (nend == NE_EXP);
        end
      end

      MODE_SYM: sym_now = 1'b1;

      default: begin
        io = idle_out(c);
        s  = idle_state(s, c);
        if (io.vld) begin
          ra[n[1:0]] = io.res;
          n = n + 1'b1;
        end
      end
    endcase

    if (sym_now) begin
      if (sym_cont(c)) begin
        s = sym_append(s, c);
        ra[n[1:0]] = mk_res(EV_BODY, TT_SYMBOL, c);
        n = n + 1'b1;
      end else begin
        ra[n[1:0]] = mk_res(EV_DONE,
                            (!s.null_miss && (s.null_cnt == 3'd4)) ? TT_NULL : TT_SYMBOL,
                            '0);
        n = n + 1'b1;
        s.mode = MODE_IDLE;
        io = idle_out(c);
        s  = idle_state(s, c);
        if (io.vld) begin
          ra[n[1:0]] = io.res;
          n = n + 1'b1;
        end
      end
    end

    if (n != '0) begin
      ra[2'(n - 1'b1)].last = 1'b1;
    end
  end

  assign st_nxt  = s;
  assign res     = ra;
  assign res_cnt = n;

endmodule

### rtl/jts_fifo.sv
module jts_fifo
  import jts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [RCNT_W-1:0]  push_cnt,
  input  result_t            push_data [MAX_RES],
  input  logic               pop,
  output result_t            head,
  output logic [FIFO_CW-1:0] count
);

  result_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Several results of one character land in consecutive slots at once.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RCNT_W'(i) < push_cnt) begin
        mem_r[FIFO_AW'(wr_ptr_r + FIFO_AW'(i))] <= push_data[i];
      end
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

### rtl/jts_checker.sv
module jts_checker
  import jts_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic [1:0]      out_event_kind,
  input logic [3:0]      out_token_type,
  input logic [CP_W-1:0] out_char_value,
  input logic            out_last
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind) &&
    $stable(out_token_type) && $stable(out_char_value) && $stable(out_last))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A bad escape is the only result of its character and belongs to a string.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_ERR) |->
    out_last && (out_token_type == TT_STRING) && (out_char_value == '0))
    else $error("malformed error result");

  // Completion and error results carry no character.
  a_nobody_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind != EV_BODY) |-> (out_char_value == '0))
    else $error("character on a non-body result");

  // Body characters belong only to strings, numbers and symbols.
  a_body_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_BODY) |->
    (out_token_type == TT_STRING) || (out_token_type == TT_NUMBER) ||
    (out_token_type == TT_SYMBOL))
    else $error("body character on a punctuation token");

endmodule

bind json_token_scanner jts_checker u_chk (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import jts_pkg::*;

  localparam int RANDOM_CHARS = 350;
  localparam int DIR_ROWS     = 26;
  localparam int TAIL_CYCLES  = 24;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {NUM_KEEP, NUM_CLOSE, NUM_CLOSE_EXP} num_verdict_t;

  // A directed row either carries its expected result typed in, or leaves
  // the expectation to the token predictor.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            typed;
    logic            has_res;
    result_t         res;
  } stim_row_t;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [CP_W-1:0] in_code_point = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      out_event_kind;
  logic [3:0]      out_token_type;
  logic [CP_W-1:0] out_char_value;
  logic            out_last;

  json_token_scanner dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_point  (in_code_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_token_type (out_token_type),
    .out_char_value (out_char_value),
    .out_last       (out_last)
  );

  // Tokenizer state as it stands after reset.
  logic [1:0]  st_mode      = MODE_IDLE;
  logic [1:0]  st_esc       = ESC_NONE;
  logic [15:0] st_hex       = '0;
  logic [2:0]  st_hex_left  = '0;
  logic [2:0]  st_num       = NM_UNDEC;
  logic        st_dot       = 1'b0;
  logic        st_upper     = 1'b0;
  logic [2:0]  st_null_cnt  = '0;
  logic        st_null_bad  = 1'b0;

  result_t         step_res [MAX_RES];
  int              step_cnt;
  result_t         token_events [$];
  result_t         oldest_event;
  logic [CP_W-1:0] text_q [$];
  stim_row_t       dir_rows [DIR_ROWS];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int chars_sent     = 0;
  int chars_counted  = 0;
  int events_seen    = 0;
  int errors_seen    = 0;
  int nulls_seen     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic dec_digit(logic [CP_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic blank(logic [CP_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic int hex_nibble(logic [CP_W-1:0] c);
    if (dec_digit(c)) return int'(c - CH_0);
    if ((c >= CH_UA) && (c <= CH_UF)) return int'(c - CH_UA) + 10;
    if ((c >= CH_LA) && (c <= CH_LF_)) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  function automatic int punct_token(logic [CP_W-1:0] c);
    case (c)
      CH_COMMA: return int'(TT_COMMA);
      CH_DOT:   return int'(TT_DOT);
      CH_LBRC:  return int'(TT_OBJ_O);
      CH_RBRC:  return int'(TT_OBJ_C);
      CH_LBRK:  return int'(TT_ARR_O);
      CH_RBRK:  return int'(TT_ARR_C);
      CH_COLON: return int'(TT_COLON);
      default:  return -1;
    endcase
  endfunction

  function void emit_event(logic [1:0] kind, logic [3:0] tt, logic [CP_W-1:0] ch);
    if (step_cnt < MAX_RES) begin
      step_res[step_cnt] = '{kind: kind, ttype: tt, ch: ch, last: 1'b0};
      step_cnt++;
    end
  endfunction

  function void sym_extend(logic [CP_W-1:0] c);
    if (!st_null_bad && (st_null_cnt < 3'd4) && (c == NULL_TEXT[st_null_cnt[1:0]])) begin
      st_null_cnt = st_null_cnt + 3'd1;
    end else begin
      st_null_bad = 1'b1;
    end
    emit_event(EV_BODY, TT_SYMBOL, c);
  endfunction

  function void scan_idle(logic [CP_W-1:0] c);
    int p;
    p = punct_token(c);
    if (blank(c)) return;
    if (p >= 0) begin
      emit_event(EV_DONE, p[3:0], '0);
    end else if (c == CH_QUOTE) begin
      st_mode = MODE_STR;
      st_esc  = ESC_NONE;
    end else if (dec_digit(c) || (c == CH_MINUS)) begin
      st_mode  = MODE_NUM;
      st_num   = (c == CH_0) ? NM_UNDEC : NM_DEC;
      st_dot   = 1'b0;
      st_upper = 1'b0;
      emit_event(EV_BODY, TT_NUMBER, c);
    end else begin
      st_mode     = MODE_SYM;
      st_null_cnt = '0;
      st_null_bad = 1'b0;
      sym_extend(c);
    end
  endfunction

  function void scan_string(logic [CP_W-1:0] c);
    int v;
    if (st_esc == ESC_BSL) begin
      if (c == CH_LU) begin
        st_esc      = ESC_HEX;
        st_hex      = '0;
        st_hex_left = 3'd4;
      end else begin
        st_esc = ESC_NONE;
        if (c == CH_LT) emit_event(EV_BODY, TT_STRING, CH_TAB);
        else if (c == CH_LN) emit_event(EV_BODY, TT_STRING, CH_LF);
        else if (c == CH_LR) emit_event(EV_BODY, TT_STRING, CH_CR);
        else emit_event(EV_BODY, TT_STRING, c);
      end
    end else if (st_esc == ESC_HEX) begin
      v = hex_nibble(c);
      if (v < 0) begin
        // A bad digit ends the string with an error result.
        emit_event(EV_ERR, TT_STRING, '0);
        st_esc      = ESC_NONE;
        st_hex      = '0;
        st_hex_left = '0;
        st_mode     = MODE_IDLE;
      end else begin
        st_hex      = {st_hex[11:0], v[3:0]};
        st_hex_left = st_hex_left - 3'd1;
        if (st_hex_left == 3'd0) begin
          st_esc = ESC_NONE;
          emit_event(EV_BODY, TT_STRING, {5'd0, st_hex});
          st_hex = '0;
        end
      end
    end else if (c == CH_QUOTE) begin
      emit_event(EV_DONE, TT_STRING, '0);
      st_mode = MODE_IDLE;
    end else if (c == CH_BSL) begin
      st_esc = ESC_BSL;
    end else begin
      emit_event(EV_BODY, TT_STRING, c);
    end
  endfunction

  function num_verdict_t scan_number(logic [CP_W-1:0] c);
    logic take;
    take = 1'b1;
    case (st_num)
      NM_UNDEC: begin
        if ((c == CH_LX) || (c == CH_UX)) st_num = NM_HEX;
        else if ((c == CH_LO) || (c == CH_UO)) st_num = NM_OCT;
        else if ((c == CH_LB) || (c == CH_UB)) st_num = NM_BIN;
        else if (c == CH_DOT) begin
          st_dot = 1'b1;
          st_num = NM_DEC;
        end else if (dec_digit(c)) st_num = NM_DEC;
        else take = 1'b0;
      end
      NM_DEC: begin
        if (dec_digit(c) || ((c == CH_DOT) && !st_dot)) begin
          if (c == CH_DOT) st_dot = 1'b1;
        end else if (((c == CH_LE) || (c == CH_UE)) && st_dot) begin
          // The letter is held back until the sign shows whether it belongs here.
          st_upper = (c == CH_UE);
          st_num   = NM_EXP;
          return NUM_KEEP;
        end else begin
          take = 1'b0;
        end
      end
      NM_EXP: begin
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          st_num = NM_EXPD;
          emit_event(EV_BODY, TT_NUMBER, CH_LE);
        end else begin
          return NUM_CLOSE_EXP;
        end
      end
      NM_EXPD: take = dec_digit(c);
      NM_HEX:  take = (hex_nibble(c) >= 0);
      NM_OCT:  take = (c >= CH_0) && (c <= CH_7);
      NM_BIN:  take = (c == CH_0) || (c == CH_1);
      default: take = 1'b0;
    endcase
    if (!take) return NUM_CLOSE;
    emit_event(EV_BODY, TT_NUMBER, c);
    return NUM_KEEP;
  endfunction

  function void scan_symbol(logic [CP_W-1:0] c);
    if (!blank(c) && (c != CH_QUOTE) && ((c == CH_DOT) || (punct_token(c) < 0))) begin
      sym_extend(c);
    end else begin
      emit_event(EV_DONE, (!st_null_bad && (st_null_cnt == 3'd4)) ? TT_NULL : TT_SYMBOL, '0);
      st_mode = MODE_IDLE;
      scan_idle(c);
    end
  endfunction

  // Works out the results one character causes and advances the state.
  function void scan_char(logic [CP_W-1:0] c);
    num_verdict_t verdict;
    step_cnt = 0;
    case (st_mode)
      MODE_STR: scan_string(c);
      MODE_NUM: begin
        verdict = scan_number(c);
        if (verdict != NUM_KEEP) begin
          emit_event(EV_DONE, TT_NUMBER, '0);
          st_mode = MODE_IDLE;
          if (verdict == NUM_CLOSE_EXP) begin
            // The held letter opens a symbol, which the current character then meets.
            scan_idle(st_upper ? CH_UE : CH_LE);
            scan_symbol(c);
          end else begin
            scan_idle(c);
          end
        end
      end
      MODE_SYM: scan_symbol(c);
      default:  scan_idle(c);
    endcase
    if (step_cnt > 0) step_res[step_cnt - 1].last = 1'b1;
  endfunction

  function automatic stim_row_t scanned(logic [CP_W-1:0] c);
    stim_row_t row;
    row         = '0;
    row.cp      = c;
    return row;
  endfunction

  function automatic stim_row_t quiet(logic [CP_W-1:0] c);
    stim_row_t row;
    row       = '0;
    row.cp    = c;
    row.typed = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t gives(logic [CP_W-1:0] c, logic [1:0] kind, logic [3:0] tt);
    stim_row_t row;
    row         = '0;
    row.cp      = c;
    row.typed   = 1'b1;
    row.has_res = 1'b1;
    row.res     = '{kind: kind, ttype: tt, ch: '0, last: 1'b1};
    return row;
  endfunction

  function automatic logic [CP_W-1:0] random_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CH_SPACE + CP_W'($urandom_range(0, 94));
      5, 6, 7:       return CP_W'($urandom_range(0, 21'h10FFFF));
      default:       return CP_W'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  function automatic logic [CP_W-1:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return CH_0 + CP_W'(v);
    if (v < 16) return CH_LA + CP_W'(v - 10);
    return CH_UA + CP_W'(v - 16);
  endfunction

  function automatic logic [CP_W-1:0] digit_char(int hi);
    return CH_0 + CP_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [CP_W-1:0] separator_char();
    case ($urandom_range(0, 10))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      4:       return CH_COMMA;
      5:       return CH_DOT;
      6:       return CH_LBRC;
      7:       return CH_RBRC;
      8:       return CH_LBRK;
      9:       return CH_RBRK;
      default: return CH_COLON;
    endcase
  endfunction

  // Appends one mostly well-formed token, sometimes followed by a separator.
  task automatic compose_token();
    int pick;
    int n;
    logic [CP_W-1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      text_q.push_back(CH_QUOTE);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 15))
          0: begin
            text_q.push_back(CH_BSL);
            case ($urandom_range(0, 2))
              0:       text_q.push_back(CH_LT);
              1:       text_q.push_back(CH_LN);
              default: text_q.push_back(CH_LR);
            endcase
          end
          1: begin
            text_q.push_back(CH_BSL);
            text_q.push_back(random_char());
          end
          2, 3: begin
            text_q.push_back(CH_BSL);
            text_q.push_back(CH_LU);
            repeat (4) text_q.push_back(hex_char());
          end
          4: begin
            text_q.push_back(CH_BSL);
            text_q.push_back(CH_LU);
            repeat ($urandom_range(0, 3)) text_q.push_back(hex_char());
            c = random_char();
            if (hex_nibble(c) >= 0) c = CP_W'("g");
            text_q.push_back(c);
            // The string is gone; whatever follows is scanned outside it.
            return;
          end
          default: begin
            do c = random_char(); while ((c == CH_QUOTE) || (c == CH_BSL));
            text_q.push_back(c);
          end
        endcase
      end
      text_q.push_back(CH_QUOTE);
    end else if (pick < 56) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          if ($urandom_range(0, 3) == 0) text_q.push_back(CH_MINUS);
          repeat ($urandom_range(1, 4)) text_q.push_back(digit_char(9));
          if ($urandom_range(0, 1) == 1) begin
            text_q.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) text_q.push_back(digit_char(9));
          end
          if ($urandom_range(0, 9) < 4) begin
            text_q.push_back(($urandom_range(0, 1) == 1) ? CH_UE : CH_LE);
            if ($urandom_range(0, 9) < 6)
              text_q.push_back(($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS);
            repeat ($urandom_range(0, 3)) text_q.push_back(digit_char(9));
          end
        end
        2: begin
          text_q.push_back(CH_0);
          text_q.push_back(($urandom_range(0, 1) == 1) ? CH_UX : CH_LX);
          repeat ($urandom_range(0, 4)) text_q.push_back(hex_char());
        end
        3: begin
          text_q.push_back(CH_0);
          text_q.push_back(($urandom_range(0, 1) == 1) ? CH_UO : CH_LO);
          repeat ($urandom_range(0, 4)) text_q.push_back(digit_char(9));
        end
        4: begin
          text_q.push_back(CH_0);
          text_q.push_back(($urandom_range(0, 1) == 1) ? CH_UB : CH_LB);
          repeat ($urandom_range(0, 6)) text_q.push_back(digit_char(2));
        end
        default: begin
          text_q.push_back(CH_0);
          if ($urandom_range(0, 1) == 1) text_q.push_back(digit_char(9));
        end
      endcase
    end else if (pick < 78) begin
      if ($urandom_range(0, 9) < 4) begin
        n = $urandom_range(2, 6);
        if (n > 5) n = 4;
        for (int i = 0; i < n; i++) text_q.push_back((i < 4) ? NULL_TEXT[i] : CH_LO);
      end else begin
        text_q.push_back(CH_LA + CP_W'($urandom_range(0, 25)));
        repeat ($urandom_range(0, 4)) text_q.push_back(random_char());
      end
    end else if (pick < 88) begin
      text_q.push_back(separator_char());
    end else begin
      repeat ($urandom_range(1, 3)) text_q.push_back(random_char());
    end
    if ($urandom_range(0, 9) < 6) text_q.push_back(separator_char());
  endtask

  // Offers one character, waits for the transaction and records what it must cause.
  task automatic send_char(input stim_row_t row);
    if ((send_idle_pct > 0) && ($urandom_range(0, 99) < send_idle_pct)) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_code_point <= row.cp;
    do @(posedge clk); while (!in_ready);
    scan_char(row.cp);
    chars_sent++;
    chars_counted++;
    if (row.typed) begin
      if (row.has_res) token_events.push_back(row.res);
    end else begin
      for (int i = 0; i < step_cnt; i++) token_events.push_back(step_res[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic [CP_W-1:0] want,
                               input logic [CP_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      events_seen++;
      if ((out_event_kind == EV_ERR)) errors_seen++;
      if ((out_event_kind == EV_DONE) && (out_token_type == TT_NULL)) nulls_seen++;
      if (token_events.size() == 0) begin
        $display({"%0t: unexpected result, expected none, ",
                  "got kind %0d type %0d char 0x%0h last %0b"},
                 $time, out_event_kind, out_token_type, out_char_value, out_last);
        fail_count++;
      end else begin
        oldest_event = token_events.pop_front();
        compare_field("event_kind", CP_W'(oldest_event.kind), CP_W'(out_event_kind));
        compare_field("token_type", CP_W'(oldest_event.ttype), CP_W'(out_token_type));
        compare_field("char_value", oldest_event.ch, out_char_value);
        compare_field("last", CP_W'(oldest_event.last), CP_W'(out_last));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timed out with %0d results still outstanding", $time, token_events.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_rows = '{
      quiet(CH_QUOTE), quiet(CH_BSL), quiet(CH_LU),
      gives(CP_W'("G"), EV_ERR, TT_STRING),
      gives(CH_LBRK, EV_DONE, TT_ARR_O),
      scanned(CH_0), scanned(CH_UX), scanned(CH_DOT),
      scanned(CH_9), scanned(CH_UE), scanned(21'h1FFFFF), scanned(CH_COMMA),
      scanned(CH_MINUS), scanned(CH_DOT), scanned(CH_UE), scanned(CH_PLUS), scanned(CH_COLON),
      scanned(CH_1), scanned(CH_DOT), scanned(CH_LE), scanned(CH_RBRK),
      scanned(NULL_TEXT[0]), scanned(NULL_TEXT[1]), scanned(NULL_TEXT[2]),
      scanned(NULL_TEXT[3]), scanned(CH_RBRC)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_char(dir_rows[i]);

    chars_counted = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      while (chars_counted < (phase + 1) * RANDOM_CHARS / 4) begin
        compose_token();
        while (text_q.size() != 0) send_char(scanned(text_q.pop_front()));
      end
    end
    in_valid <= 1'b0;

    while (token_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Scanned %0d characters, %0d of them from the directed table, %s",
             chars_sent, DIR_ROWS, "under four pacing mixes.");
    $display("Checked %0d results, among them %0d escape errors and %0d null tokens.",
             events_seen, errors_seen, nulls_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
